// ----- rtl/pcp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the convex polygon point test: sizes, command codes, the
// record that travels down the cell chain and the edge sign check.
// No dependencies.
package pcp_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_BITS   = 16;

  localparam int IDX_W  = 4;                              // vertex_index field
  localparam int CNT_W  = 5;                              // vertex_count register
  localparam int NEFF_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (NEFF_W > CNT_W) ? NEFF_W : CNT_W;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(4);
  localparam logic [CMP_W-1:0] VCOUNT_MIN   = CMP_W'(3);
  localparam logic [CMP_W-1:0] VCOUNT_MAX   = CMP_W'(MAX_VERTICES);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEST = 1'b1
  } cmd_t;

  // One query point on its way along the chain. The two products belong
  // to the edge of the previous cell and are compared by the next one.
  typedef struct packed {
    logic                     valid;
    logic                     ok;
    logic                     chk;
    logic [COORD_BITS-1:0]    qx;
    logic [COORD_BITS-1:0]    qy;
    logic [PROD_W-1:0]        pa;
    logic [PROD_W-1:0]        pb;
  } stage_t;

  function automatic logic [DIFF_W-1:0] sext_coord(input logic [COORD_BITS-1:0] v);
    sext_coord = {v[COORD_BITS-1], v};
  endfunction

  // Running inside flag after folding in the pending edge's cross sign.
  function automatic logic edge_ok(input stage_t s);
    edge_ok = s.ok & (!s.chk | ($signed(s.pa) > $signed(s.pb)));
  endfunction

endpackage

// ----- rtl/point_in_convex_polygon_top.sv -----
`timescale 1ns / 1ps
// Top level of the convex polygon point test: a chain of vertex cells,
// the entry and result registers and the vertex_count register. Uses pcp_pkg.
//
// Usage: the input channel (in_valid / in_stall) carries a command with
// vertex_index, coord_x and coord_y. A load command writes one vertex in
// the transfer cycle and produces no result. A test command sends the query
// point down a chain of MAX_VERTICES cells, one cell per cycle; each cell
// checks the edge from its own vertex to the next one in use, and the last
// edge closes back to vertex zero. The result (inside_res, one bit) passes
// through the entry, cell and output registers to the output channel
// (out_valid / out_stall). While a test is in the chain, in_stall is high,
// so tests run one after another; loads do not block the input. The next
// item is taken as soon as the result sits in the output register, even if
// the receiver stalls it. A stalled result holds; a later test moves on
// until it reaches the last cell, then the chain freezes until the result
// is taken. The user must write vertex_count over cfg_valid / cfg_ready /
// cfg_data only while the block is idle; the block itself does not enforce
// it. cfg_ready is always high. Synchronous reset empties the chain and the
// output and sets vertex_count to 4; vertex storage is not cleared.
module point_in_convex_polygon_top
  import pcp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [IDX_W-1:0]             vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CNT_W-1:0]             cfg_data
);

  logic [CNT_W-1:0]      vertex_count;
  logic [CMP_W-1:0]      count_ext;
  logic [NEFF_W-1:0]     n_eff;
  logic                  busy;
  logic                  adv;
  logic                  in_xfer;
  logic                  test_xfer;
  logic                  load_xfer;
  logic                  out_load;
  logic                  entry_valid;
  logic [COORD_BITS-1:0] entry_qx;
  logic [COORD_BITS-1:0] entry_qy;
  stage_t                stg [MAX_VERTICES+1];
  logic [COORD_BITS-1:0] vx [MAX_VERTICES];
  logic [COORD_BITS-1:0] vy [MAX_VERTICES];

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign in_xfer   = in_valid & ~in_stall;
  assign test_xfer = in_xfer & (cmd_t'(command) == CMD_TEST);
  assign load_xfer = in_xfer & (cmd_t'(command) == CMD_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // Counts below three act as three, counts above the cell count as full.
  always_comb begin
    count_ext = CMP_W'(vertex_count);
    if (count_ext < VCOUNT_MIN) begin
      n_eff = NEFF_W'(VCOUNT_MIN);
    end else if (count_ext > VCOUNT_MAX) begin
      n_eff = NEFF_W'(VCOUNT_MAX);
    end else begin
      n_eff = NEFF_W'(count_ext);
    end
  end

  // The chain moves unless a finished result cannot leave.
  assign out_load = ~out_valid | ~out_stall;
  assign adv      = ~stg[MAX_VERTICES].valid | out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (adv) begin
      entry_valid <= test_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (test_xfer) begin
      entry_qx <= coord_x;
      entry_qy <= coord_y;
    end
  end

  always_comb begin
    stg[0]       = '0;
    stg[0].valid = entry_valid;
    stg[0].ok    = 1'b1;
    stg[0].qx    = entry_qx;
    stg[0].qy    = entry_qy;
  end

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    logic [COORD_BITS-1:0] nx, ny;
    logic                  on;

    if (i + 1 < MAX_VERTICES) begin : g_mid
      always_comb begin
        if (n_eff == NEFF_W'(i + 1)) begin
          nx = vx[0];
          ny = vy[0];
        end else begin
          nx = vx[i+1];
          ny = vy[i+1];
        end
      end
    end else begin : g_last
      assign nx = vx[0];
      assign ny = vy[0];
    end

    assign on = NEFF_W'(i) < n_eff;

    pcp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ld_en   (load_xfer && (vertex_index == IDX_W'(i))),
      .ld_x    (coord_x),
      .ld_y    (coord_y),
      .next_x  (nx),
      .next_y  (ny),
      .edge_on (on),
      .prev    (stg[i]),
      .vert_x  (vx[i]),
      .vert_y  (vy[i]),
      .stage   (stg[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stg[MAX_VERTICES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inside_res <= edge_ok(stg[MAX_VERTICES]);
    end
  end

  // One test in flight; it ends when its result enters the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (test_xfer) begin
      busy <= 1'b1;
    end else if (stg[MAX_VERTICES].valid && out_load) begin
      busy <= 1'b0;
    end
  end

endmodule

// ----- rtl/pcp_cell.sv -----
`timescale 1ns / 1ps
// One cell of the chain: stores one polygon vertex and forms the two
// cross-product terms of the edge that starts at it. Uses pcp_pkg.
module pcp_cell
  import pcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  ld_en,
  input  logic [COORD_BITS-1:0] ld_x,
  input  logic [COORD_BITS-1:0] ld_y,
  input  logic [COORD_BITS-1:0] next_x,
  input  logic [COORD_BITS-1:0] next_y,
  input  logic                  edge_on,
  input  stage_t                prev,
  output logic [COORD_BITS-1:0] vert_x,
  output logic [COORD_BITS-1:0] vert_y,
  output stage_t                stage
);

  logic signed [DIFF_W-1:0] ex, ey, dx, dy;
  logic signed [PROD_W-1:0] pa_next, pb_next;

  always_ff @(posedge clk) begin
    if (ld_en) begin
      vert_x <= ld_x;
      vert_y <= ld_y;
    end
  end

  always_comb begin
    ex = $signed(sext_coord(next_x)) - $signed(sext_coord(vert_x));
    ey = $signed(sext_coord(next_y)) - $signed(sext_coord(vert_y));
    dx = $signed(sext_coord(prev.qx)) - $signed(sext_coord(vert_x));
    dy = $signed(sext_coord(prev.qy)) - $signed(sext_coord(vert_y));
    pa_next = ex * dy;
    pb_next = ey * dx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage.valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage.ok  <= edge_ok(prev);
      stage.chk <= edge_on;
      stage.qx  <= prev.qx;
      stage.qy  <= prev.qy;
      stage.pa  <= pa_next;
      stage.pb  <= pb_next;
    end
  end

endmodule

// ----- rtl/pcp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the convex polygon point test, bound to the top
// level. Uses pcp_pkg.
module pcp_checker
  import pcp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic command,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("stalled result changed or vanished");

  // A test transfer blocks the input while the point walks the chain.
  a_test_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_TEST |=> in_stall)
    else $error("input not blocked after a test transfer");

  // A load never blocks the next item.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_LOAD |=> !in_stall)
    else $error("input blocked after a load transfer");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind point_in_convex_polygon_top pcp_checker u_pcp_checker (.*);
